### design/mex_pkg.sv
// Shared types, opcode and function codes for the MIPS execute stage with forwarding.
package mex_pkg;

  localparam int unsigned XLEN = 32;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_BGTZ  = 6'h07;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0A;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_NORI  = 6'h0E;
  localparam logic [5:0] OP_LUI   = 6'h0F;
  localparam logic [5:0] OP_LB    = 6'h20;
  localparam logic [5:0] OP_LH    = 6'h21;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_LBU   = 6'h24;
  localparam logic [5:0] OP_LHU   = 6'h25;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2B;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_NAND = 6'h28;
  localparam logic [5:0] FN_SLT  = 6'h2A;

  typedef logic [XLEN-1:0] word_t;
  typedef logic [4:0]      reg_idx_t;

  // Input request, ex_instr in the lowest bits.
  typedef struct packed {
    logic     pad;
    word_t    id_b;
    word_t    id_a;
    word_t    id_instr;
    word_t    mem_result;
    reg_idx_t mem_dest;
    logic     ex_dest_is_rd;
    logic     ex_reg_write;
    word_t    ex_b;
    word_t    ex_a;
    word_t    ex_instr;
  } in_t;

  // Result request, alu_result in the lowest bits.
  typedef struct packed {
    logic [4:0] pad;
    logic       stall_res;
    logic       branch_forwarded;
    word_t      branch_b;
    word_t      branch_a;
    logic       ex_forwarded;
    word_t      store_data;
    word_t      alu_result;
  } out_t;

  // Forwarding unit results toward the ALU and the result register.
  typedef struct packed {
    word_t op_a;
    word_t op_b;
    logic  ex_fwd;
    word_t br_a;
    word_t br_b;
    logic  br_fwd;
    logic  stall;
  } fwd_t;

  function automatic logic is_branch(input logic [5:0] op);
    return (op == OP_BEQ) || (op == OP_BNE) || (op == OP_BGTZ);
  endfunction

endpackage

### design/mex_fwd.sv
// Operand forwarding from EX/MEM for EX and ID-branch operands, plus branch hazard stall.
module mex_fwd (
  input  mex_pkg::in_t  req,
  output mex_pkg::fwd_t fwd
);

  logic [5:0]        op;
  logic [5:0]        fn;
  mex_pkg::reg_idx_t rs;
  mex_pkg::reg_idx_t rt;
  mex_pkg::reg_idx_t rd;
  mex_pkg::reg_idx_t dst;
  logic [5:0]        id_op;
  mex_pkg::reg_idx_t id_rs;
  mex_pkg::reg_idx_t id_rt;
  logic              use_rs;
  logic              use_rt;
  logic              hit_rs;
  logic              hit_rt;
  logic              hit_id_rs;
  logic              hit_id_rt;
  logic              id_br;

  assign op    = req.ex_instr[31:26];
  assign rs    = req.ex_instr[25:21];
  assign rt    = req.ex_instr[20:16];
  assign rd    = req.ex_instr[15:11];
  assign fn    = req.ex_instr[5:0];
  assign id_op = req.id_instr[31:26];
  assign id_rs = req.id_instr[25:21];
  assign id_rt = req.id_instr[20:16];
  assign id_br = mex_pkg::is_branch(id_op);

  always_comb begin
    use_rs = 1'b0;
    use_rt = 1'b0;
    if (op == mex_pkg::OP_RTYPE) begin
      case (fn)
        mex_pkg::FN_ADD, mex_pkg::FN_ADDU, mex_pkg::FN_SUB, mex_pkg::FN_AND,
        mex_pkg::FN_OR, mex_pkg::FN_XOR, mex_pkg::FN_NOR, mex_pkg::FN_NAND,
        mex_pkg::FN_SLT: begin
          use_rs = 1'b1;
          use_rt = 1'b1;
        end
        mex_pkg::FN_SLL, mex_pkg::FN_SRL, mex_pkg::FN_SRA: begin
          use_rt = 1'b1;
        end
        default: begin
        end
      endcase
    end else begin
      case (op)
        mex_pkg::OP_ADDI, mex_pkg::OP_ADDIU, mex_pkg::OP_LB, mex_pkg::OP_LH,
        mex_pkg::OP_LW, mex_pkg::OP_LBU, mex_pkg::OP_LHU, mex_pkg::OP_SLTI,
        mex_pkg::OP_ANDI, mex_pkg::OP_ORI, mex_pkg::OP_NORI: begin
          use_rs = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign hit_rs    = (req.mem_dest != '0) && use_rs && (req.mem_dest == rs);
  assign hit_rt    = (req.mem_dest != '0) && use_rt && (req.mem_dest == rt);
  assign hit_id_rs = (req.mem_dest != '0) && id_br && (req.mem_dest == id_rs);
  assign hit_id_rt = (req.mem_dest != '0) && id_br && (req.mem_dest == id_rt);

  // destination zero still stalls
  assign dst = req.ex_dest_is_rd ? rd : rt;

  assign fwd.op_a   = hit_rs ? req.mem_result : req.ex_a;
  assign fwd.op_b   = hit_rt ? req.mem_result : req.ex_b;
  assign fwd.ex_fwd = hit_rs | hit_rt;
  assign fwd.br_a   = hit_id_rs ? req.mem_result : req.id_a;
  assign fwd.br_b   = hit_id_rt ? req.mem_result : req.id_b;
  assign fwd.br_fwd = hit_id_rs | hit_id_rt;
  assign fwd.stall  = req.ex_reg_write && id_br && ((id_rs == dst) || (id_rt == dst));

endmodule

### design/mex_alu.sv
// ALU for the EX instruction on forwarded operands.
module mex_alu (
  input  mex_pkg::word_t instr,
  input  mex_pkg::word_t op_a,
  input  mex_pkg::word_t op_b,
  output mex_pkg::word_t result
);

  logic [5:0]     op;
  logic [5:0]     fn;
  logic [4:0]     sh;
  mex_pkg::word_t uimm;
  mex_pkg::word_t simm;

  assign op   = instr[31:26];
  assign fn   = instr[5:0];
  assign sh   = instr[10:6];
  assign uimm = {16'h0000, instr[15:0]};
  assign simm = {{16{instr[15]}}, instr[15:0]};

  always_comb begin
    result = '0;
    if (op == mex_pkg::OP_RTYPE) begin
      case (fn)
        mex_pkg::FN_ADD, mex_pkg::FN_ADDU: result = op_a + op_b;
        mex_pkg::FN_SUB:  result = op_a - op_b;
        mex_pkg::FN_AND:  result = op_a & op_b;
        mex_pkg::FN_OR:   result = op_a | op_b;
        mex_pkg::FN_XOR:  result = op_a ^ op_b;
        mex_pkg::FN_NOR:  result = ~(op_a | op_b);
        mex_pkg::FN_NAND: result = ~(op_a & op_b);
        mex_pkg::FN_SLT:  result = {31'd0, $signed(op_a) < $signed(op_b)};
        mex_pkg::FN_SLL:  result = op_b << sh;
        mex_pkg::FN_SRL:  result = op_b >> sh;
        mex_pkg::FN_SRA:  result = mex_pkg::word_t'($signed(op_b) >>> sh);
        default:          result = '0;
      endcase
    end else begin
      case (op)
        mex_pkg::OP_ADDI, mex_pkg::OP_ADDIU, mex_pkg::OP_LB, mex_pkg::OP_LH,
        mex_pkg::OP_LW, mex_pkg::OP_LBU, mex_pkg::OP_LHU, mex_pkg::OP_SB,
        mex_pkg::OP_SH, mex_pkg::OP_SW: result = op_a + simm;
        mex_pkg::OP_LUI:  result = {instr[15:0], 16'h0000};
        mex_pkg::OP_ANDI: result = op_a & uimm;
        mex_pkg::OP_ORI:  result = op_a | uimm;
        mex_pkg::OP_NORI: result = ~(op_a | uimm);
        mex_pkg::OP_SLTI: result = {31'd0, $signed(op_a) < $signed(simm)};
        default:          result = '0;
      endcase
    end
  end

endmodule

### design/mips_execute_stage_with_forwarding.sv
// Top level: input register, forwarding and ALU logic, result register.
//
// Each request is captured in an input register, resolved combinationally by the
// forwarding unit and ALU, and held in a result register until taken; that register
// drives out_tvalid and out_tdata. One request is taken per cycle while the result
// side keeps up, and in_tready drops only when both registers are full and
// out_tready is low. The 32-bit adder with the operand forwarding mux ahead of it
// sets the critical path.
module mips_execute_stage_with_forwarding (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // ex_instr[31:0] ex_a[63:32] ex_b[95:64] ex_reg_write[96] ex_dest_is_rd[97]
  // mem_dest[102:98] mem_result[134:103] id_instr[166:135] id_a[198:167]
  // id_b[230:199], zero[231]
  input  logic [231:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // alu_result[31:0] store_data[63:32] ex_forwarded[64] branch_a[96:65]
  // branch_b[128:97] branch_forwarded[129] stall_res[130], zero[135:131]
  output logic [135:0] out_tdata
);

  mex_pkg::in_t   in_r;
  logic           in_vld_r;
  mex_pkg::out_t  out_r;
  mex_pkg::out_t  out_nxt;
  logic           out_vld_r;
  logic           adv;
  mex_pkg::fwd_t  fwd;
  mex_pkg::word_t alu_res;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || adv;

  mex_fwd u_fwd (
    .req (in_r),
    .fwd (fwd)
  );

  mex_alu u_alu (
    .instr  (in_r.ex_instr),
    .op_a   (fwd.op_a),
    .op_b   (fwd.op_b),
    .result (alu_res)
  );

  always_comb begin
    out_nxt                  = '0;
    out_nxt.alu_result       = alu_res;
    out_nxt.store_data       = fwd.op_b;
    out_nxt.ex_forwarded     = fwd.ex_fwd;
    out_nxt.branch_a         = fwd.br_a;
    out_nxt.branch_b         = fwd.br_b;
    out_nxt.branch_forwarded = fwd.br_fwd;
    out_nxt.stall_res        = fwd.stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_r <= mex_pkg::in_t'(in_tdata);
    end
    if (adv && in_vld_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

endmodule

### dv/tb_mips_execute_stage_with_forwarding.sv
// Testbench for the MIPS execute stage with forwarding: scoreboard, stimulus and checks.
module tb_mips_execute_stage_with_forwarding;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [5:0] OP_UNUSED = 6'h3F;
  localparam logic [5:0] FN_UNUSED = 6'h3F;
  localparam int         N_RANDOM  = 1280;
  localparam int         LONG_HOLD = 60;

  class exec_scoreboard;
    mex_pkg::out_t pending_results[$];
    int            errors;

    function new();
      errors = 0;
    endfunction

    task report(string field, mex_pkg::word_t got, mex_pkg::word_t want);
      errors++;
      $display("%0t mismatch %s: got %h want %h", $realtime, field, got, want);
    endtask

    // Forwarding, ALU and branch hazard logic for one request.
    function mex_pkg::out_t execute_forward(mex_pkg::in_t r);
      logic [5:0]     op, fn, id_op;
      logic [4:0]     rs, rt, rd, sh, id_rs, id_rt, dst;
      mex_pkg::word_t a, b, uimm, simm, res;
      logic           use_rs, use_rt, br, exf, brf;
      mex_pkg::out_t  o;
      op     = r.ex_instr[31:26];
      rs     = r.ex_instr[25:21];
      rt     = r.ex_instr[20:16];
      rd     = r.ex_instr[15:11];
      sh     = r.ex_instr[10:6];
      fn     = r.ex_instr[5:0];
      uimm   = {16'h0, r.ex_instr[15:0]};
      simm   = {{16{r.ex_instr[15]}}, r.ex_instr[15:0]};
      id_op  = r.id_instr[31:26];
      id_rs  = r.id_instr[25:21];
      id_rt  = r.id_instr[20:16];
      a      = r.ex_a;
      b      = r.ex_b;
      o      = '0;
      use_rs = 1'b0;
      use_rt = 1'b0;
      exf    = 1'b0;
      brf    = 1'b0;
      o.branch_a = r.id_a;
      o.branch_b = r.id_b;

      if (op == mex_pkg::OP_RTYPE) begin
        case (fn)
          mex_pkg::FN_ADD, mex_pkg::FN_ADDU, mex_pkg::FN_SUB, mex_pkg::FN_AND,
          mex_pkg::FN_OR, mex_pkg::FN_XOR, mex_pkg::FN_NOR, mex_pkg::FN_NAND,
          mex_pkg::FN_SLT: begin
            use_rs = 1'b1;
            use_rt = 1'b1;
          end
          mex_pkg::FN_SLL, mex_pkg::FN_SRL, mex_pkg::FN_SRA: use_rt = 1'b1;
          default: ;
        endcase
      end else begin
        case (op)
          mex_pkg::OP_ADDI, mex_pkg::OP_ADDIU, mex_pkg::OP_LB, mex_pkg::OP_LH,
          mex_pkg::OP_LW, mex_pkg::OP_LBU, mex_pkg::OP_LHU, mex_pkg::OP_SLTI,
          mex_pkg::OP_ANDI, mex_pkg::OP_ORI, mex_pkg::OP_NORI: use_rs = 1'b1;
          default: ;
        endcase
      end

      case (id_op)
        mex_pkg::OP_BEQ, mex_pkg::OP_BNE, mex_pkg::OP_BGTZ: br = 1'b1;
        default: br = 1'b0;
      endcase

      if (r.mem_dest != 5'd0) begin
        if (use_rs && r.mem_dest == rs) begin
          a   = r.mem_result;
          exf = 1'b1;
        end
        if (use_rt && r.mem_dest == rt) begin
          b   = r.mem_result;
          exf = 1'b1;
        end
        if (br && r.mem_dest == id_rs) begin
          o.branch_a = r.mem_result;
          brf        = 1'b1;
        end
        if (br && r.mem_dest == id_rt) begin
          o.branch_b = r.mem_result;
          brf        = 1'b1;
        end
      end

      res = '0;
      if (op == mex_pkg::OP_RTYPE) begin
        case (fn)
          mex_pkg::FN_ADD, mex_pkg::FN_ADDU: res = a + b;
          mex_pkg::FN_SUB:  res = a - b;
          mex_pkg::FN_AND:  res = a & b;
          mex_pkg::FN_OR:   res = a | b;
          mex_pkg::FN_XOR:  res = a ^ b;
          mex_pkg::FN_NOR:  res = ~(a | b);
          mex_pkg::FN_NAND: res = ~(a & b);
          mex_pkg::FN_SLT:  res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
          mex_pkg::FN_SLL:  res = b << sh;
          mex_pkg::FN_SRL:  res = b >> sh;
          mex_pkg::FN_SRA:  res = $signed(b) >>> sh;
          default: res = '0;
        endcase
      end else begin
        case (op)
          mex_pkg::OP_ADDI, mex_pkg::OP_ADDIU, mex_pkg::OP_LB, mex_pkg::OP_LH,
          mex_pkg::OP_LW, mex_pkg::OP_LBU, mex_pkg::OP_LHU, mex_pkg::OP_SB,
          mex_pkg::OP_SH, mex_pkg::OP_SW: res = a + simm;
          mex_pkg::OP_LUI:  res = uimm << 16;
          mex_pkg::OP_ANDI: res = a & uimm;
          mex_pkg::OP_ORI:  res = a | uimm;
          mex_pkg::OP_NORI: res = ~(a | uimm);
          mex_pkg::OP_SLTI: res = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
          default: res = '0;
        endcase
      end

      // no zero-register exemption on the stall compare
      dst = r.ex_dest_is_rd ? rd : rt;
      o.stall_res        = r.ex_reg_write && br && (id_rs == dst || id_rt == dst);
      o.alu_result       = res;
      o.store_data       = b;
      o.ex_forwarded     = exf;
      o.branch_forwarded = brf;
      return o;
    endfunction

    function void note_request(mex_pkg::in_t r);
      pending_results.push_back(execute_forward(r));
    endfunction

    task check_result(mex_pkg::out_t got);
      mex_pkg::out_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result", got.alu_result, '0);
        return;
      end
      want = pending_results.pop_front();
      if (got.alu_result !== want.alu_result)
        report("alu_result", got.alu_result, want.alu_result);
      if (got.store_data !== want.store_data)
        report("store_data", got.store_data, want.store_data);
      if (got.ex_forwarded !== want.ex_forwarded)
        report("ex_forwarded", mex_pkg::word_t'(got.ex_forwarded),
               mex_pkg::word_t'(want.ex_forwarded));
      if (got.branch_a !== want.branch_a)
        report("branch_a", got.branch_a, want.branch_a);
      if (got.branch_b !== want.branch_b)
        report("branch_b", got.branch_b, want.branch_b);
      if (got.branch_forwarded !== want.branch_forwarded)
        report("branch_forwarded", mex_pkg::word_t'(got.branch_forwarded),
               mex_pkg::word_t'(want.branch_forwarded));
      if (got.stall_res !== want.stall_res)
        report("stall_res", mex_pkg::word_t'(got.stall_res),
               mex_pkg::word_t'(want.stall_res));
    endtask
  endclass

  logic           clk;
  logic           rst_n;
  logic           in_tvalid;
  logic           in_tready;
  logic [231:0]   in_tdata;
  logic           out_tvalid;
  logic           out_tready;
  logic [135:0]   out_tdata;
  exec_scoreboard sb;
  int             results_taken;

  mips_execute_stage_with_forwarding DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(mex_pkg::in_t'(in_tdata));
      if (out_tvalid && out_tready) sb.check_result(mex_pkg::out_t'(out_tdata));
    end
  end

  function automatic mex_pkg::word_t rtype(mex_pkg::reg_idx_t rs, mex_pkg::reg_idx_t rt,
                                           mex_pkg::reg_idx_t rd, logic [4:0] sh,
                                           logic [5:0] fn);
    return {mex_pkg::OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function automatic mex_pkg::word_t itype(logic [5:0] op, mex_pkg::reg_idx_t rs,
                                           mex_pkg::reg_idx_t rt, logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic mex_pkg::in_t mk(mex_pkg::word_t ex_instr, mex_pkg::word_t a,
                                      mex_pkg::word_t b, logic rw, logic to_rd,
                                      mex_pkg::reg_idx_t md, mex_pkg::word_t mres,
                                      mex_pkg::word_t id_instr,
                                      mex_pkg::word_t ia, mex_pkg::word_t ib);
    mex_pkg::in_t r;
    r               = '0;
    r.ex_instr      = ex_instr;
    r.ex_a          = a;
    r.ex_b          = b;
    r.ex_reg_write  = rw;
    r.ex_dest_is_rd = to_rd;
    r.mem_dest      = md;
    r.mem_result    = mres;
    r.id_instr      = id_instr;
    r.id_a          = ia;
    r.id_b          = ib;
    return r;
  endfunction

  function automatic mex_pkg::word_t rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Mostly low registers so that forwarding and hazard matches happen often.
  function automatic mex_pkg::reg_idx_t rand_reg();
    if ($urandom_range(0, 3) != 0) return mex_pkg::reg_idx_t'($urandom_range(0, 3));
    return mex_pkg::reg_idx_t'($urandom_range(0, 31));
  endfunction

  function automatic logic [5:0] rand_funct();
    case ($urandom_range(0, 12))
      0:  return mex_pkg::FN_SLL;
      1:  return mex_pkg::FN_SRL;
      2:  return mex_pkg::FN_SRA;
      3:  return mex_pkg::FN_ADD;
      4:  return mex_pkg::FN_ADDU;
      5:  return mex_pkg::FN_SUB;
      6:  return mex_pkg::FN_AND;
      7:  return mex_pkg::FN_OR;
      8:  return mex_pkg::FN_XOR;
      9:  return mex_pkg::FN_NOR;
      10: return mex_pkg::FN_NAND;
      11: return mex_pkg::FN_SLT;
      default: return 6'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic logic [5:0] rand_iop();
    case ($urandom_range(0, 18))
      0:  return mex_pkg::OP_ADDI;
      1:  return mex_pkg::OP_ADDIU;
      2:  return mex_pkg::OP_SLTI;
      3:  return mex_pkg::OP_ANDI;
      4:  return mex_pkg::OP_ORI;
      5:  return mex_pkg::OP_NORI;
      6:  return mex_pkg::OP_LUI;
      7:  return mex_pkg::OP_LB;
      8:  return mex_pkg::OP_LH;
      9:  return mex_pkg::OP_LW;
      10: return mex_pkg::OP_LBU;
      11: return mex_pkg::OP_LHU;
      12: return mex_pkg::OP_SB;
      13: return mex_pkg::OP_SH;
      14: return mex_pkg::OP_SW;
      15: return mex_pkg::OP_BEQ;
      default: return 6'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic mex_pkg::in_t rand_request();
    mex_pkg::word_t ex_w, id_w;
    logic [5:0]     id_op;
    if ($urandom_range(0, 1) == 0)
      ex_w = rtype(rand_reg(), rand_reg(), rand_reg(),
                   5'($urandom_range(0, 31)), rand_funct());
    else
      ex_w = itype(rand_iop(), rand_reg(), rand_reg(), 16'($urandom()));
    if ($urandom_range(0, 7) == 0) ex_w = $urandom();
    case ($urandom_range(0, 4))
      0: id_op = mex_pkg::OP_BEQ;
      1: id_op = mex_pkg::OP_BNE;
      2: id_op = mex_pkg::OP_BGTZ;
      default: id_op = 6'($urandom_range(0, 63));
    endcase
    id_w = itype(id_op, rand_reg(), rand_reg(), 16'($urandom()));
    return mk(ex_w, rand_word(), rand_word(), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), rand_reg(), rand_word(), id_w,
              rand_word(), rand_word());
  endfunction

  task automatic send_request(input mex_pkg::in_t req, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= req;
    do @(posedge clk); while (!in_tready);
  endtask

  // Result side: random stalls, idle-free stretches, and a couple of long holds.
  initial begin
    int hold;
    out_tready    = 1'b0;
    results_taken = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (results_taken == 30 || results_taken == 700) hold = LONG_HOLD;
      else if ((results_taken / 120) % 3 == 1) hold = 0;
      else hold = $urandom_range(0, 3);
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      results_taken++;
    end
  end

  initial begin
    #(2_000_000);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int gap;
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // ALU ops with forwarding on rs, rt or both
    send_request(mk(rtype(1, 2, 3, 0, mex_pkg::FN_ADD), 32'h7FFF_FFFF, 32'h1, 1, 1, 1,
                    32'h7FFF_FFFF, 0, 0, 0), 0);
    send_request(mk(rtype(4, 2, 5, 0, mex_pkg::FN_ADDU), 32'hFFFF_FFFF, 0, 1, 1, 2,
                    32'h1, 0, 0, 0), $urandom_range(0, 3));
    send_request(mk(rtype(2, 2, 6, 0, mex_pkg::FN_SUB), 0, 0, 1, 1, 2, 32'h8000_0000,
                    0, 0, 0), 0);
    send_request(mk(rtype(3, 4, 1, 0, mex_pkg::FN_AND), 32'hF0F0_F0F0, 32'hFFFF_0000,
                    1, 1, 0, 32'hFFFF_FFFF, 0, 0, 0), $urandom_range(0, 3));
    send_request(mk(rtype(3, 4, 1, 0, mex_pkg::FN_OR), 32'hF0F0_F0F0, 32'h0F0F_0000,
                    0, 0, 4, 32'h1234_5678, 0, 0, 0), 0);
    send_request(mk(rtype(3, 4, 1, 0, mex_pkg::FN_XOR), 32'hFFFF_FFFF, 32'hAAAA_5555,
                    0, 0, 0, 0, 0, 0, 0), 0);
    send_request(mk(rtype(3, 4, 1, 0, mex_pkg::FN_NOR), 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
    send_request(mk(rtype(3, 4, 1, 0, mex_pkg::FN_NAND), 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    0, 0, 0, 0, 0, 0, 0), 0);
    send_request(mk(rtype(3, 4, 1, 0, mex_pkg::FN_SLT), 32'h8000_0000, 32'h7FFF_FFFF,
                    0, 0, 0, 0, 0, 0, 0), 0);
    // shifts: rs never forwarded, extreme shift amounts
    send_request(mk(rtype(7, 8, 9, 31, mex_pkg::FN_SLL), 32'h5, 32'h1, 0, 0, 7,
                    32'hDEAD_BEEF, 0, 0, 0), 2);
    send_request(mk(rtype(7, 8, 9, 31, mex_pkg::FN_SRL), 0, 32'h8000_0000, 0, 0, 0, 0,
                    0, 0, 0), 0);
    send_request(mk(rtype(7, 8, 9, 31, mex_pkg::FN_SRA), 0, 32'h8000_0000, 0, 0, 8,
                    32'h8000_0000, 0, 0, 0), 0);
    send_request(mk(rtype(7, 8, 9, 0, mex_pkg::FN_SRA), 0, 32'h8000_0001, 0, 0, 0, 0,
                    0, 0, 0), 3);
    // register zero is never forwarded
    send_request(mk(rtype(0, 0, 1, 0, mex_pkg::FN_ADD), 32'h11, 32'h22, 1, 1, 0,
                    32'hFFFF_FFFF, 0, 0, 0), 0);
    // immediate forms
    send_request(mk(itype(mex_pkg::OP_ADDI, 5, 6, 16'h8000), 32'h1, 0, 1, 0, 5, 0,
                    0, 0, 0), 0);
    send_request(mk(itype(mex_pkg::OP_SW, 5, 6, 16'h7FFF), 32'h1, 32'h2, 0, 0, 5,
                    32'h100, 0, 0, 0), 0);
    send_request(mk(itype(mex_pkg::OP_SLTI, 5, 6, 16'hFFFF), 32'h8000_0000, 0, 1, 0, 0,
                    0, 0, 0, 0), 1);
    send_request(mk(itype(mex_pkg::OP_ANDI, 5, 6, 16'hFFFF), 0, 0, 1, 0, 5,
                    32'hFFFF_FFFF, 0, 0, 0), 0);
    send_request(mk(itype(mex_pkg::OP_NORI, 5, 6, 16'hFFFF), 0, 0, 1, 0, 0, 0,
                    0, 0, 0), 0);
    send_request(mk(itype(mex_pkg::OP_LUI, 5, 6, 16'hFFFF), 32'h1234, 0, 1, 0, 5, 32'h9,
                    0, 0, 0), 0);
    // unknown opcode and unknown function code
    send_request(mk(itype(OP_UNUSED, 1, 2, 16'hFFFF), 32'hFFFF_FFFF, 32'h3, 1, 0, 1,
                    32'h77, 0, 0, 0), 0);
    send_request(mk(rtype(1, 2, 3, 0, FN_UNUSED), 32'hFFFF_FFFF, 32'h3, 1, 1, 2,
                    32'h77, 0, 0, 0), 0);
    // branch in decode: forwarding and hazard stall
    send_request(mk(rtype(1, 2, 4, 0, mex_pkg::FN_ADD), 0, 0, 1, 1, 3, 32'hCAFE_0001,
                    itype(mex_pkg::OP_BEQ, 3, 4, 0), 32'h10, 32'h20), 0);
    send_request(mk(itype(mex_pkg::OP_ORI, 1, 9, 16'h1), 0, 0, 0, 0, 4, 32'hCAFE_0002,
                    itype(mex_pkg::OP_BNE, 1, 4, 0), 32'h10, 32'h20), 2);
    // destination register zero still stalls
    send_request(mk(itype(mex_pkg::OP_ADDI, 1, 0, 16'h1), 0, 0, 1, 0, 0, 32'hCAFE_0003,
                    itype(mex_pkg::OP_BGTZ, 0, 5, 0), 32'h30, 32'h40), 0);
    // non-branch in decode: no forwarding, no stall
    send_request(mk(rtype(1, 2, 3, 0, mex_pkg::FN_ADD), 0, 0, 1, 1, 3, 32'hCAFE_0004,
                    itype(mex_pkg::OP_ADDI, 3, 3, 0), 32'h50, 32'h60), 0);

    for (int i = 0; i < N_RANDOM; i++) begin
      gap = ((i / 150) % 3 == 2) ? 0 : $urandom_range(0, 3);
      send_request(rand_request(), gap);
    end
    in_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
design/mex_pkg.sv
design/mex_fwd.sv
design/mex_alu.sv
design/mips_execute_stage_with_forwarding.sv
dv/tb_mips_execute_stage_with_forwarding.sv
